// ===== hw/rtl/tenc_pkg.sv =====
// Shared types, constants and helpers for the tile edge neighbor classifier.
// Used by tenc_line_buffer and tile_edge_neighbor_classifier; no dependencies.
package tenc_pkg;

    localparam int DEFAULT_MAX_WIDTH = 256;
    localparam int TILE_W            = 8;
    localparam int SIZE_W            = 9;
    localparam int LIMIT_W           = 4;
    localparam int COUNT_W           = 17;
    localparam int CFG_IDX_W         = 3;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd3;
    localparam logic [SIZE_W-1:0] MAX_HEIGHT = 9'd256;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH   = 3'd0,
        CFG_GRID_HEIGHT  = 3'd1,
        CFG_TARGET_TILE  = 3'd2,
        CFG_REPLACE_TILE = 3'd3,
        CFG_EDGE_LIMIT   = 3'd4,
        CFG_BORDER_TILE  = 3'd5
    } cfg_idx_t;

    // Register values after reset.
    localparam logic [SIZE_W-1:0]  RST_GRID_WIDTH   = 9'd128;
    localparam logic [SIZE_W-1:0]  RST_GRID_HEIGHT  = 9'd128;
    localparam logic [TILE_W-1:0]  RST_TARGET_TILE  = 8'd101;
    localparam logic [TILE_W-1:0]  RST_REPLACE_TILE = 8'd7;
    localparam logic [LIMIT_W-1:0] RST_EDGE_LIMIT   = 4'd2;
    localparam logic [TILE_W-1:0]  RST_BORDER_TILE  = 8'd0;

    // One input item.
    typedef struct packed {
        logic [TILE_W-1:0] cell_tile;
        logic              drain;
    } cell_item_t;

    // One result item.
    typedef struct packed {
        logic [TILE_W-1:0] out_tile;
        logic              is_edge;
        logic              frame_last;
    } res_item_t;

    // Line buffer port controls.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } lb_ctrl_t;

    // One column of the two line stores: previous row and the row before it.
    typedef struct packed {
        logic [TILE_W-1:0] mid;
        logic [TILE_W-1:0] top;
    } lb_data_t;

    // Limit a grid size to the supported range.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < SIZE_MIN)
        begin
            r = SIZE_MIN;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/tenc_line_buffer.sv =====
// Two line stores (previous row and the row before it) with a registered read port.
// Depends on tenc_pkg for the control and data structs.
module tenc_line_buffer
    import tenc_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
)
(
    input  logic             clk,
    input  lb_ctrl_t         ctrl,
    input  logic [COL_W-1:0] rd_col,
    input  logic [COL_W-1:0] wr_col,
    input  lb_data_t         wr_data,
    output lb_data_t         rd_data
);

    logic [TILE_W-1:0] line_store_a [0:MAX_WIDTH-1];
    logic [TILE_W-1:0] line_store_b [0:MAX_WIDTH-1];
    lb_data_t          rd_data_reg;

    // Write the column retired by the window stage.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            line_store_a[wr_col] <= wr_data.mid;
            line_store_b[wr_col] <= wr_data.top;
        end
    end

    // Read the column of the incoming item; a write to the same column in this
    // cycle is forwarded so the read sees the updated entry.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            if (ctrl.wr_en && (wr_col == rd_col))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg.mid <= line_store_a[rd_col];
                rd_data_reg.top <= line_store_b[rd_col];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/tile_edge_neighbor_classifier.sv =====
// Top level of the tile edge neighbor classifier: raster counters, 3x3 window,
// edge decision and result register. Depends on tenc_pkg and tenc_line_buffer.
//
//   channel   signals                          direction  item
//   cfg       cfg_we, cfg_index, cfg_data      in         register write, no wait
//   cell      cell_valid, cell_ready, cell_item in        one tile id or a drain
//   res       res_valid, res_ready, res_item   out        one classified cell
//
// One item per cycle while results are taken. An item is counted at acceptance,
// reads the line stores in that cycle, and updates the window and line stores as
// it retires from the window stage, when its result, if any, is also registered.
// Reset clears counters, window and valid flags and loads the register defaults;
// the line stores are not cleared. cell_ready drops only while the window stage
// holds a result that the full result register cannot yet take.
module tile_edge_neighbor_classifier
    import tenc_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 cell_valid,
    output logic                 cell_ready,
    input  cell_item_t           cell_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_item_t            res_item
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW    = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;
    localparam logic [SIZE_W-1:0] W_HI =
        (MAX_WIDTH >= (1 << SIZE_W)) ? {SIZE_W{1'b1}} : SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0]  W_RST     = clamp_size(RST_GRID_WIDTH, W_HI);
    localparam logic [SIZE_W-1:0]  H_RST     = clamp_size(RST_GRID_HEIGHT, MAX_HEIGHT);
    localparam logic [COUNT_W-1:0] TOTAL_RST = COUNT_W'(W_RST) * COUNT_W'(H_RST);

    // Configuration registers (sizes kept already clamped).
    logic [SIZE_W-1:0]  w_cl_reg, w_cl_next;
    logic [SIZE_W-1:0]  h_cl_reg, h_cl_next;
    logic [TILE_W-1:0]  target_reg, target_next;
    logic [TILE_W-1:0]  replace_reg, replace_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [TILE_W-1:0]  border_reg, border_next;
    logic [COUNT_W-1:0] total_reg, total_next;

    // Raster counters.
    logic [COL_W-1:0]   col_reg, col_next;
    logic [SIZE_W-1:0]  row_reg, row_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;

    // Acceptance stage signals.
    logic               rs_count, rs_row, wrap_in, wrap_out;
    logic [COL_W-1:0]   col_a, col_b, col1;
    logic [SIZE_W-1:0]  row_a, row1;
    logic [SIZE_W:0]    row_b;
    logic [COUNT_W-1:0] cnt_a, cnt1;
    logic [XW-1:0]      w_x, col_inc;
    logic               input_done, ignore, emit, last;
    logic [TILE_W-1:0]  value;
    logic               accept, s1_load, s1_fire, s1_adv;

    // Window stage registers.
    logic               s1_valid_reg;
    logic [TILE_W-1:0]  s1_value_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic               s1_col0_reg, s1_emit_reg, s1_last_reg;
    logic [COUNT_W-1:0] s1_cnt_reg;

    logic [TILE_W-1:0]  win_reg  [0:8];
    logic [TILE_W-1:0]  win_next [0:8];
    logic [TILE_W-1:0]  ws       [0:8];
    logic [TILE_W-1:0]  nb       [0:8];
    logic [TILE_W-1:0]  center;
    logic [LIMIT_W-1:0] diff_count;
    logic               first_row, final_row, edge_hit;
    res_item_t          res_next;

    // Result register.
    logic               res_valid_reg;
    res_item_t          res_item_reg;

    // Line buffer connection.
    lb_ctrl_t           lb_ctrl;
    lb_data_t           lb_wr, lb_rd;

    // Configuration write decode; the plane size follows the written values.
    always_comb
    begin
        w_cl_next    = w_cl_reg;
        h_cl_next    = h_cl_reg;
        target_next  = target_reg;
        replace_next = replace_reg;
        limit_next   = limit_reg;
        border_next  = border_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:   w_cl_next    = clamp_size(cfg_data, W_HI);
                CFG_GRID_HEIGHT:  h_cl_next    = clamp_size(cfg_data, MAX_HEIGHT);
                CFG_TARGET_TILE:  target_next  = cfg_data[TILE_W-1:0];
                CFG_REPLACE_TILE: replace_next = cfg_data[TILE_W-1:0];
                CFG_EDGE_LIMIT:   limit_next   = cfg_data[LIMIT_W-1:0];
                CFG_BORDER_TILE:  border_next  = cfg_data[TILE_W-1:0];
                default:          ;
            endcase
        end
        total_next = COUNT_W'(w_cl_next) * COUNT_W'(h_cl_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_cl_reg    <= W_RST;
            h_cl_reg    <= H_RST;
            target_reg  <= RST_TARGET_TILE;
            replace_reg <= RST_REPLACE_TILE;
            limit_reg   <= RST_EDGE_LIMIT;
            border_reg  <= RST_BORDER_TILE;
            total_reg   <= TOTAL_RST;
        end
        else
        begin
            w_cl_reg    <= w_cl_next;
            h_cl_reg    <= h_cl_next;
            target_reg  <= target_next;
            replace_reg <= replace_next;
            limit_reg   <= limit_next;
            border_reg  <= border_next;
            total_reg   <= total_next;
        end
    end

    // Handshake: the window stage moves on unless its result finds the output full.
    assign s1_adv     = !s1_emit_reg || !res_valid_reg || res_ready;
    assign s1_fire    = s1_valid_reg && s1_adv;
    assign cell_ready = !s1_valid_reg || s1_adv;
    assign accept     = cell_valid && cell_ready;
    assign s1_load    = accept && !ignore;

    // Normalize the counters, then classify the incoming item.
    always_comb
    begin
        w_x      = XW'(w_cl_reg);
        rs_count = cnt_reg >= total_reg;
        col_a    = rs_count ? '0 : col_reg;
        row_a    = rs_count ? '0 : row_reg;
        cnt_a    = rs_count ? '0 : cnt_reg;
        wrap_in  = XW'(col_a) >= w_x;
        col_b    = wrap_in ? '0 : col_a;
        row_b    = wrap_in ? ({1'b0, row_a} + (SIZE_W+1)'(1)) : {1'b0, row_a};
        rs_row   = row_b > ({1'b0, h_cl_reg} + (SIZE_W+1)'(1));
        col1     = rs_row ? '0 : col_b;
        row1     = rs_row ? '0 : row_b[SIZE_W-1:0];
        cnt1     = rs_row ? '0 : cnt_a;

        input_done = row1 >= h_cl_reg;
        ignore     = cell_item.drain && !input_done;
        value      = input_done ? border_reg : cell_item.cell_tile;
        emit       = (row1 >= SIZE_W'(2)) || ((row1 == SIZE_W'(1)) && (col1 != '0));
        last       = emit && ((cnt1 + COUNT_W'(1)) == total_reg);
        col_inc    = XW'(col1) + XW'(1);
        wrap_out   = col_inc >= w_x;
    end

    // Counter update at acceptance.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (ignore)
            begin
                col_next = col1;
                row_next = row1;
                cnt_next = cnt1;
            end
            else if (last)
            begin
                col_next = '0;
                row_next = '0;
                cnt_next = '0;
            end
            else
            begin
                cnt_next = emit ? (cnt1 + COUNT_W'(1)) : cnt1;
                col_next = wrap_out ? '0 : col_inc[COL_W-1:0];
                row_next = wrap_out ? (row1 + SIZE_W'(1)) : row1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
        end
    end

    // Window stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Window stage payload.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_value_reg <= value;
            s1_col_reg   <= col1;
            s1_col0_reg  <= (col1 == '0);
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
            s1_cnt_reg   <= cnt1;
        end
    end

    // Line stores: read at acceptance, written when the window stage retires.
    assign lb_ctrl.rd_en = s1_load;
    assign lb_ctrl.wr_en = s1_fire;
    assign lb_wr.mid     = s1_value_reg;
    assign lb_wr.top     = lb_rd.mid;

    tenc_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk     (clk),
        .ctrl    (lb_ctrl),
        .rd_col  (col1),
        .wr_col  (s1_col_reg),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    // Shift the window, mask rows outside the grid and count differing neighbors.
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            ws[k] = win_reg[k + 3];
        end
        ws[6] = s1_col0_reg ? border_reg : lb_rd.top;
        ws[7] = s1_col0_reg ? border_reg : lb_rd.mid;
        ws[8] = s1_col0_reg ? border_reg : s1_value_reg;

        first_row = s1_cnt_reg < COUNT_W'(w_cl_reg);
        final_row = s1_cnt_reg >= (total_reg - COUNT_W'(w_cl_reg));
        for (int k = 0; k < 9; k++)
        begin
            nb[k] = ws[k];
        end
        for (int c = 0; c < 3; c++)
        begin
            if (first_row)
            begin
                nb[c * 3] = border_reg;
            end
            if (final_row)
            begin
                nb[c * 3 + 2] = border_reg;
            end
        end

        center     = nb[4];
        diff_count = '0;
        for (int k = 0; k < 9; k++)
        begin
            if ((k != 4) && (nb[k] != center))
            begin
                diff_count = diff_count + LIMIT_W'(1);
            end
        end
        edge_hit = (center == target_reg) && (diff_count >= limit_reg);

        res_next.out_tile   = edge_hit ? replace_reg : center;
        res_next.is_edge    = edge_hit;
        res_next.frame_last = s1_last_reg;

        // At the start of a row the left columns restart from the border.
        for (int k = 0; k < 9; k++)
        begin
            win_next[k] = ws[k];
        end
        if (s1_col0_reg)
        begin
            win_next[3] = border_reg;
            win_next[4] = border_reg;
            win_next[5] = border_reg;
            win_next[6] = lb_rd.top;
            win_next[7] = lb_rd.mid;
            win_next[8] = s1_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (s1_fire)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_emit_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit_reg)
        begin
            res_item_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // A result blocked in the window stage must hold off new items.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit_reg && res_valid_reg && !res_ready) |-> !cell_ready)
        else $error("window stage overrun while result register is full");

    // A result in flight always refers to a cell inside the plane.
    a_count_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit_reg) |-> (s1_cnt_reg < total_reg))
        else $error("result index beyond plane size");

    // An ignored drain item must not enter the window stage.
    a_drain_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ignore && !s1_valid_reg) |=> !s1_valid_reg)
        else $error("ignored drain item entered the window stage");

endmodule

// ===== sim/tb_tile_edge_neighbor_classifier.sv =====
// Self-checking testbench for tile_edge_neighbor_classifier: streams tile planes, predicts
// every classified cell in its own model and compares results. Depends on tenc_pkg and the RTL.
`timescale 1ns / 100ps

module tb_tile_edge_neighbor_classifier;
    import tenc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int ITEM_GOAL   = 1450;
    localparam int WIDE_PHASE  = 4;

    // One row of the directed plan: the item and, where fixed is set, its typed result.
    typedef struct packed {
        logic             drain;
        logic [TILE_W-1:0] tile;
        logic             fixed;
        res_item_t        want;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;
    logic                 cell_valid;
    logic                 cell_ready;
    cell_item_t           cell_item;
    logic                 res_valid;
    logic                 res_ready;
    res_item_t            res_item;

    // Register copies as the block should hold them.
    logic [SIZE_W-1:0]  grid_w_reg;
    logic [SIZE_W-1:0]  grid_h_reg;
    logic [TILE_W-1:0]  target_reg;
    logic [TILE_W-1:0]  replace_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [TILE_W-1:0]  border_reg;

    // Predictor state: two rows of history, the 3x3 window and the raster counters.
    logic [TILE_W-1:0] row_near [DEFAULT_MAX_WIDTH];
    logic [TILE_W-1:0] row_far [DEFAULT_MAX_WIDTH];
    logic [TILE_W-1:0] win [9];
    int                cur_col;
    int                cur_row;
    int                emit_idx;

    res_item_t expect_q [$];
    int        err_count    = 0;
    int        items_done   = 0;
    int        quiet_cycles = 0;
    bit        tx_burst     = 1'b0;
    bit        rx_burst     = 1'b0;
    bit        hold_pending = 1'b0;

    // A 3x3 plane under the reset registers: target 101, replacement 7, limit 2, border 0.
    // It opens with a drain that must be ignored and flushes with three drains and one discarded cell.
    plan_row_t intro_plan [14] = '{
        '{1'b1, 8'd0,   1'b0, '0},
        '{1'b0, 8'd101, 1'b0, '0},
        '{1'b0, 8'd101, 1'b0, '0},
        '{1'b0, 8'd101, 1'b0, '0},
        '{1'b0, 8'd101, 1'b0, '0},
        '{1'b0, 8'd101, 1'b1, '{8'd7, 1'b1, 1'b0}},
        '{1'b0, 8'd255, 1'b0, '0},
        '{1'b0, 8'd0,   1'b0, '0},
        '{1'b0, 8'd101, 1'b0, '0},
        '{1'b0, 8'd101, 1'b1, '{8'd7, 1'b1, 1'b0}},
        '{1'b1, 8'd0,   1'b1, '{8'd255, 1'b0, 1'b0}},
        '{1'b0, 8'd200, 1'b1, '{8'd0, 1'b0, 1'b0}},
        '{1'b1, 8'd255, 1'b0, '0},
        '{1'b1, 8'd0,   1'b1, '{8'd7, 1'b1, 1'b1}}
    };

    tile_edge_neighbor_classifier u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_item  (cell_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    // Effective plane sizes after saturation.
    function automatic int eff_width();
        if (grid_w_reg < SIZE_MIN)
            return SIZE_MIN;
        if (grid_w_reg > DEFAULT_MAX_WIDTH)
            return DEFAULT_MAX_WIDTH;
        return grid_w_reg;
    endfunction

    function automatic int eff_height();
        if (grid_h_reg < SIZE_MIN)
            return SIZE_MIN;
        if (grid_h_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return grid_h_reg;
    endfunction

    function automatic void rewind_frame();
        cur_col  = 0;
        cur_row  = 0;
        emit_idx = 0;
    endfunction

    // Advances the predictor by one item. Returns 1 when the item produces a result;
    // used is 0 for a drain that arrives before the plane is complete.
    function automatic bit classify_cell(input cell_item_t it, output res_item_t r,
                                         output bit used);
        int                w, h, total, c, n, orow, diff;
        logic [TILE_W-1:0] bd, val, top, mid, center;
        logic [TILE_W-1:0] nb [9];
        bit                flushing, last, has;
        w     = eff_width();
        h     = eff_height();
        total = w * h;
        bd    = border_reg;
        r     = '0;
        used  = 1'b0;
        has   = 1'b0;
        last  = 1'b0;

        if (emit_idx >= total)
            rewind_frame();
        if (cur_col >= w)
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row > h + 1)
            rewind_frame();

        flushing = (cur_row >= h);
        if (it.drain && !flushing)
            return 1'b0;
        used = 1'b1;
        val  = flushing ? bd : it.cell_tile;

        // Line stores move down one row at this column.
        c   = cur_col;
        n   = cur_row * w + c;
        top = row_far[c];
        mid = row_near[c];
        row_far[c]  = mid;
        row_near[c] = val;

        // A new row starts with a border column on the right of the last cell.
        for (int k = 0; k < 6; k++)
            win[k] = win[k + 3];
        win[6] = (c == 0) ? bd : top;
        win[7] = (c == 0) ? bd : mid;
        win[8] = (c == 0) ? bd : val;

        // The cell one row and one column back is now complete.
        if (n >= w + 1)
        begin
            orow = emit_idx / w;
            nb   = win;
            if (orow == 0)
            begin
                nb[0] = bd;
                nb[3] = bd;
                nb[6] = bd;
            end
            if (orow == h - 1)
            begin
                nb[2] = bd;
                nb[5] = bd;
                nb[8] = bd;
            end
            center = nb[4];
            diff   = 0;
            for (int k = 0; k < 9; k++)
                if (k != 4 && nb[k] != center)
                    diff++;
            has          = 1'b1;
            r.is_edge    = (center == target_reg) && (diff >= limit_reg);
            r.out_tile   = r.is_edge ? replace_reg : center;
            last         = (emit_idx + 1 == total);
            r.frame_last = last;
        end

        // The first column of a row gets a border column on its left.
        if (c == 0)
        begin
            win[3] = bd;
            win[4] = bd;
            win[5] = bd;
            win[6] = top;
            win[7] = mid;
            win[8] = val;
        end

        if (has && last)
        begin
            rewind_frame();
            return 1'b1;
        end
        if (has)
            emit_idx++;
        cur_col++;
        if (cur_col >= w)
        begin
            cur_col = 0;
            cur_row++;
        end
        return has;
    endfunction

    task automatic flag(input string what);
        err_count++;
        if (err_count <= 10)
            $display("ERROR: %s", what);
    endtask

    // Register write; the block must be idle.
    task automatic write_reg(input cfg_idx_t idx, input logic [SIZE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_GRID_WIDTH:   grid_w_reg  = data;
            CFG_GRID_HEIGHT:  grid_h_reg  = data;
            CFG_TARGET_TILE:  target_reg  = data[TILE_W-1:0];
            CFG_REPLACE_TILE: replace_reg = data[TILE_W-1:0];
            CFG_EDGE_LIMIT:   limit_reg   = data[LIMIT_W-1:0];
            CFG_BORDER_TILE:  border_reg  = data[TILE_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one item and, once it is taken, records what it should produce.
    task automatic push_cell(input cell_item_t it, input bit fixed, input res_item_t want);
        int        gap;
        res_item_t r;
        bit        has, used;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            cell_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_item  <= it;
        @(posedge clk);
        while (!cell_ready)
            @(posedge clk);
        has = classify_cell(it, r, used);
        if (fixed)
            expect_q.push_back(want);
        else if (has)
            expect_q.push_back(r);
        if (used)
            items_done++;
    endtask

    task automatic wait_drained(input int settle_cycles);
        do
            @(posedge clk);
        while (expect_q.size() != 0);
        repeat (settle_cycles) @(posedge clk);
    endtask

    function automatic logic [TILE_W-1:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly target and border tiles so that edges are frequent.
    function automatic logic [TILE_W-1:0] pick_tile();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return target_reg;
            5, 6:          return border_reg;
            7:             return replace_reg;
            default:       return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // New register setting for one phase; sizes always written, others at random, all in phase 0.
    task automatic retune(input int phase);
        logic [SIZE_W-1:0]  wv, hv;
        logic [LIMIT_W-1:0] lv;
        logic [TILE_W-1:0]  bv;
        bit                 all;
        all = (phase == 0);
        case (phase)
            1:
            begin
                wv = 9'd8;
                hv = 9'd6;
            end
            WIDE_PHASE:
            begin
                wv = 9'($urandom_range(256, 511));
                hv = 9'($urandom_range(0, 3));
            end
            default:
            begin
                wv = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 2))
                                                 : 9'($urandom_range(3, 9));
                hv = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 2))
                                                 : 9'($urandom_range(3, 7));
            end
        endcase
        write_reg(CFG_GRID_WIDTH, wv);
        write_reg(CFG_GRID_HEIGHT, hv);
        if (all || $urandom_range(0, 1))
            write_reg(CFG_TARGET_TILE, {1'($urandom_range(0, 1)), pick_byte()});
        if (all || $urandom_range(0, 1))
            write_reg(CFG_REPLACE_TILE, {1'($urandom_range(0, 1)), pick_byte()});
        if (all || $urandom_range(0, 1))
        begin
            // Zero marks every target cell, above eight marks none.
            case ($urandom_range(0, 9))
                0:       lv = 4'd0;
                1:       lv = 4'($urandom_range(9, 15));
                2:       lv = 4'd1;
                3:       lv = 4'd8;
                default: lv = 4'($urandom_range(1, 8));
            endcase
            write_reg(CFG_EDGE_LIMIT, {5'($urandom_range(0, 31)), lv});
        end
        if (all || $urandom_range(0, 1))
        begin
            bv = ($urandom_range(0, 3) == 0) ? target_reg : pick_byte();
            write_reg(CFG_BORDER_TILE, {1'($urandom_range(0, 1)), bv});
        end
    endtask

    // One whole plane followed by its flush. Stray drains inside the plane are ignored;
    // flush items are drains or cells whose tile is discarded.
    task automatic run_plane(input int pause_at);
        int         w, h;
        cell_item_t it;
        w = eff_width();
        h = eff_height();
        for (int k = 0; k < w * h; k++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                it.drain     = 1'b1;
                it.cell_tile = 8'($urandom_range(0, 255));
                push_cell(it, 1'b0, '0);
            end
            it.drain     = 1'b0;
            it.cell_tile = pick_tile();
            push_cell(it, 1'b0, '0);
            if (k == pause_at)
            begin
                cell_valid <= 1'b0;
                wait_drained(0);
            end
        end
        for (int k = 0; k <= w; k++)
        begin
            it.drain     = 1'($urandom_range(0, 1));
            it.cell_tile = 8'($urandom_range(0, 255));
            push_cell(it, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, and one long hold-off when asked for.
    initial
    begin : result_sink
        int gap;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = rx_burst ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        res_item_t want_r;
        if (rst_n && res_valid && res_ready)
        begin
            if (expect_q.size() == 0)
            begin
                flag($sformatf("unexpected result: tile %0d edge %0b last %0b",
                               res_item.out_tile, res_item.is_edge, res_item.frame_last));
            end
            else
            begin
                want_r = expect_q.pop_front();
                if (want_r.out_tile !== res_item.out_tile ||
                    want_r.is_edge !== res_item.is_edge ||
                    want_r.frame_last !== res_item.frame_last)
                begin
                    flag($sformatf("expected tile %0d edge %0b last %0b, got %0d %0b %0b",
                                   want_r.out_tile, want_r.is_edge, want_r.frame_last,
                                   res_item.out_tile, res_item.is_edge,
                                   res_item.frame_last));
                end
            end
        end
    end

    // Watchdog: too many cycles with nothing accepted on either side.
    always @(posedge clk)
    begin
        if ((cell_valid && cell_ready) || (res_valid && res_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int         phase;
        cell_item_t it;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_GRID_WIDTH;
        cfg_data    = '0;
        cell_valid  = 1'b0;
        cell_item   = '0;
        grid_w_reg  = RST_GRID_WIDTH;
        grid_h_reg  = RST_GRID_HEIGHT;
        target_reg  = RST_TARGET_TILE;
        replace_reg = RST_REPLACE_TILE;
        limit_reg   = RST_EDGE_LIMIT;
        border_reg  = RST_BORDER_TILE;
        foreach (row_near[i])
        begin
            row_near[i] = '0;
            row_far[i]  = '0;
        end
        foreach (win[i])
            win[i] = '0;
        rewind_frame();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plane: sizes below the minimum saturate to 3x3.
        write_reg(CFG_GRID_WIDTH, 9'd0);
        write_reg(CFG_GRID_HEIGHT, 9'd2);
        foreach (intro_plan[i])
        begin
            it.drain     = intro_plan[i].drain;
            it.cell_tile = intro_plan[i].tile;
            push_cell(it, intro_plan[i].fixed, intro_plan[i].want);
        end
        cell_valid <= 1'b0;

        // Random phases: one register setting each, one or two planes.
        phase = 0;
        while (items_done < ITEM_GOAL || phase <= WIDE_PHASE)
        begin
            wait_drained(4);
            retune(phase);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if (phase == 1)
            begin
                // Output held off while input keeps coming, so the block backs up.
                hold_pending = 1'b1;
                tx_burst     = 1'b1;
                rx_burst     = 1'b0;
            end
            run_plane((phase == 2) ? eff_width() * eff_height() / 2 : -1);
            if (phase != WIDE_PHASE && $urandom_range(0, 3) == 0)
                run_plane(-1);
            cell_valid <= 1'b0;
            phase++;
        end

        wait_drained(20);
        if (expect_q.size() != 0)
            flag($sformatf("%0d results never arrived", expect_q.size()));
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
